[rtl/core/aicp_pkg.sv]
// Shared types and constants for the animated image container parser.
// No dependencies; used by the queue, the parser and the top level.
package aicp_pkg;

	typedef logic [4:0] phase_t;

	localparam phase_t P_MAGIC   = 5'd0;
	localparam phase_t P_HSIZE   = 5'd1;
	localparam phase_t P_CSIZE   = 5'd2;
	localparam phase_t P_WIDTH   = 5'd3;
	localparam phase_t P_HEIGHT  = 5'd4;
	localparam phase_t P_CAPTION = 5'd5;
	localparam phase_t P_TAGS    = 5'd6;
	localparam phase_t P_PIX     = 5'd7;
	localparam phase_t P_BID     = 5'd8;
	localparam phase_t P_LHDR    = 5'd9;
	localparam phase_t P_LCRED   = 5'd10;
	localparam phase_t P_LANIM   = 5'd11;
	localparam phase_t P_HMAGIC  = 5'd12;
	localparam phase_t P_HSZ     = 5'd13;
	localparam phase_t P_NANIM   = 5'd14;
	localparam phase_t P_DATE    = 5'd15;
	localparam phase_t P_CLEN    = 5'd16;
	localparam phase_t P_CSKIP   = 5'd17;
	localparam phase_t P_DUR     = 5'd18;
	localparam phase_t P_END     = 5'd19;

	localparam logic [3:0] ERR_NONE      = 4'd0;
	localparam logic [3:0] ERR_BLOCK_ID  = 4'd1;
	localparam logic [3:0] ERR_HDR_LEN   = 4'd2;
	localparam logic [3:0] ERR_CONT_MAG  = 4'd3;
	localparam logic [3:0] ERR_CREATOR   = 4'd4;
	localparam logic [3:0] ERR_IMG_MAG   = 4'd5;
	localparam logic [3:0] ERR_SIZE      = 4'd6;
	localparam logic [3:0] ERR_CAPTION   = 4'd7;
	localparam logic [3:0] ERR_TAG       = 4'd8;

	localparam logic [1:0] WARN_NONE     = 2'd0;
	localparam logic [1:0] WARN_NO_ANIM  = 2'd1;
	localparam logic [1:0] WARN_CREDITS  = 2'd2;

	localparam logic [7:0] ID_HEADER     = 8'd1;
	localparam logic [7:0] ID_CREDITS    = 8'd2;
	localparam logic [7:0] ID_ANIM       = 8'd3;

	localparam logic [31:0] MAGIC_IMAGE  = 32'h4646_4943;
	localparam logic [31:0] MAGIC_CONT   = 32'h4646_4143;
	localparam int unsigned HDR_BLOCK_LEN = 20;
	localparam int unsigned IMG_FIXED    = 37;
	localparam int unsigned CRED_FIXED   = 14;
	localparam logic [7:0] CHAR_NL       = 8'h0A;
	localparam logic [7:0] CHAR_NUL      = 8'h00;

	// Front-to-back byte queue status.
	typedef struct packed {
		logic       avail;
		logic [7:0] data;
	} q_head_t;

endpackage

[rtl/core/aicp_queue.sv]
// Front end: two-entry byte queue between the input channel and the parser.
// Depends on aicp_pkg.
module aicp_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        data_byte,
	input  logic              pop,
	output aicp_pkg::q_head_t head
);

	logic [7:0] mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;

	assign in_ready = (count_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign head.avail = (count_q != 2'd0);
	assign head.data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

endmodule

[rtl/core/aicp_parser.sv]
// Back end: byte-serial parse state machine with a registered result stage.
// Depends on aicp_pkg.
module aicp_parser #(
	parameter int SIZE_WIDTH = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              mode_we,
	input  logic              mode_wdata,
	input  aicp_pkg::q_head_t head,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              pixel_valid,
	output logic [7:0]        red,
	output logic [7:0]        green,
	output logic [7:0]        blue,
	output logic              tag_end,
	output logic [1:0]        warning,
	output logic [3:0]        error_code,
	output logic              done_res
);

	localparam int W = SIZE_WIDTH;

	aicp_pkg::phase_t    phase_q, phase_n;
	logic [2:0]          cnt_q, cnt_n;
	logic [63:0]         field_q, field_n, full;
	logic [W-1:0]        blen_q, blen_n, hrem_q, hrem_n;
	logic                hshort_q, hshort_n;
	logic [W-1:0]        content_q, content_n, w3_q, w3_n, prod_q, prod_n;
	logic [W-1:0]        cap_q, cap_n, left_q, left_n, part, prod_sum, fv;
	logic [15:0]         pix_q, pix_n;
	logic [1:0]          pph_q, pph_n;
	logic [3:0]          err_q, err_n;
	logic                fin_q, fin_n;
	logic                pv, te;
	logic [1:0]          warn;
	logic [7:0]          r, g, bl, b;

	assign b    = head.data;
	assign pop  = head.avail && (!out_valid || out_ready);
	assign full = field_q | (64'(b) << {cnt_q, 3'b000});
	assign fv   = full[W-1:0];
	assign part = W'(w3_q * W'(b)) << {cnt_q, 3'b000};
	assign prod_sum = prod_q + part;

	always_comb begin
		phase_n = phase_q; cnt_n = cnt_q; field_n = field_q;
		blen_n = blen_q; hrem_n = hrem_q; hshort_n = hshort_q;
		content_n = content_q; w3_n = w3_q; prod_n = prod_q; cap_n = cap_q;
		left_n = left_q; pix_n = pix_q; pph_n = pph_q; err_n = err_q; fin_n = fin_q;
		pv = 1'b0; te = 1'b0; warn = aicp_pkg::WARN_NONE;
		r = 8'd0; g = 8'd0; bl = 8'd0;
		if (err_q == aicp_pkg::ERR_NONE && !fin_q) begin
			// Default field accumulation; phases that end a field override.
			cnt_n   = cnt_q + 3'd1;
			field_n = full;
			unique case (phase_q) inside
				aicp_pkg::P_MAGIC, aicp_pkg::P_HMAGIC: begin
					if (cnt_q == 3'd3) begin
						cnt_n = 3'd0; field_n = '0;
						if (phase_q == aicp_pkg::P_MAGIC) begin
							if (full[31:0] != aicp_pkg::MAGIC_IMAGE)
								err_n = aicp_pkg::ERR_IMG_MAG;
							else phase_n = aicp_pkg::P_HSIZE;
						end else begin
							if (full[31:0] != aicp_pkg::MAGIC_CONT)
								err_n = aicp_pkg::ERR_CONT_MAG;
							else phase_n = aicp_pkg::P_HSZ;
						end
					end
				end
				aicp_pkg::P_DATE: begin
					if (cnt_q == 3'd5) begin
						cnt_n = 3'd0; field_n = '0; phase_n = aicp_pkg::P_CLEN;
					end
				end
				aicp_pkg::P_HSIZE, aicp_pkg::P_CSIZE, aicp_pkg::P_WIDTH,
				aicp_pkg::P_HEIGHT, aicp_pkg::P_LHDR, aicp_pkg::P_LCRED,
				aicp_pkg::P_LANIM, aicp_pkg::P_HSZ, aicp_pkg::P_NANIM,
				aicp_pkg::P_CLEN, aicp_pkg::P_DUR: begin
					if (phase_q == aicp_pkg::P_HEIGHT) prod_n = prod_sum;
					if (cnt_q == 3'd7) begin
						cnt_n = 3'd0; field_n = '0;
						unique case (phase_q)
							aicp_pkg::P_HSIZE: begin
								hrem_n   = fv - W'(aicp_pkg::IMG_FIXED);
								hshort_n = fv < W'(aicp_pkg::IMG_FIXED);
								phase_n  = aicp_pkg::P_CSIZE;
							end
							aicp_pkg::P_CSIZE: begin
								content_n = fv; phase_n = aicp_pkg::P_WIDTH;
							end
							aicp_pkg::P_WIDTH: begin
								w3_n = fv + (fv << 1); prod_n = '0;
								phase_n = aicp_pkg::P_HEIGHT;
							end
							aicp_pkg::P_HEIGHT: begin
								if (prod_sum != content_q) err_n = aicp_pkg::ERR_SIZE;
								else begin
									cap_n = '0; phase_n = aicp_pkg::P_CAPTION;
								end
							end
							aicp_pkg::P_LHDR: begin
								blen_n = fv;
								if (fv != W'(aicp_pkg::HDR_BLOCK_LEN))
									err_n = aicp_pkg::ERR_HDR_LEN;
								else phase_n = aicp_pkg::P_HMAGIC;
							end
							aicp_pkg::P_LCRED: begin
								blen_n = fv; phase_n = aicp_pkg::P_DATE;
							end
							aicp_pkg::P_LANIM: begin
								blen_n = fv; phase_n = aicp_pkg::P_DUR;
							end
							aicp_pkg::P_HSZ: phase_n = aicp_pkg::P_NANIM;
							aicp_pkg::P_NANIM: begin
								if (fv == '0) warn = aicp_pkg::WARN_NO_ANIM;
								phase_n = aicp_pkg::P_BID;
							end
							aicp_pkg::P_CLEN: begin
								if (fv > blen_q) err_n = aicp_pkg::ERR_CREATOR;
								else begin
									if (fv + W'(aicp_pkg::CRED_FIXED) != blen_q)
										warn = aicp_pkg::WARN_CREDITS;
									left_n  = fv;
									phase_n = (fv == '0) ? aicp_pkg::P_BID
									                     : aicp_pkg::P_CSKIP;
								end
							end
							default: phase_n = aicp_pkg::P_MAGIC;
						endcase
					end
				end
				aicp_pkg::P_CAPTION: begin
					cnt_n = cnt_q; field_n = field_q;
					if (b == aicp_pkg::CHAR_NL) begin
						if (hshort_q || cap_q > hrem_q) err_n = aicp_pkg::ERR_CAPTION;
						else if (hrem_q == cap_q) begin
							pph_n = 2'd0;
							if (content_q == '0) begin
								fin_n = 1'b1; phase_n = aicp_pkg::P_END;
							end else begin
								left_n = content_q; phase_n = aicp_pkg::P_PIX;
							end
						end else begin
							left_n = hrem_q - cap_q; phase_n = aicp_pkg::P_TAGS;
						end
					end else if (cap_q != '1) begin
						cap_n = cap_q + W'(1);
					end
				end
				aicp_pkg::P_TAGS: begin
					cnt_n = cnt_q; field_n = field_q;
					left_n = left_q - W'(1);
					if (b == aicp_pkg::CHAR_NUL) begin
						te = 1'b1;
						if (left_q == W'(1)) begin
							pph_n = 2'd0;
							if (content_q == '0) begin
								fin_n = 1'b1; phase_n = aicp_pkg::P_END;
							end else begin
								left_n = content_q; phase_n = aicp_pkg::P_PIX;
							end
						end
					end else if (left_q == W'(1)) begin
						err_n = aicp_pkg::ERR_TAG;
					end
				end
				aicp_pkg::P_PIX: begin
					cnt_n = cnt_q; field_n = field_q;
					case (pph_q)
						2'd0: begin pix_n = {8'd0, b}; pph_n = 2'd1; end
						2'd1: begin pix_n = {b, pix_q[7:0]}; pph_n = 2'd2; end
						default: begin
							pv = 1'b1; r = pix_q[7:0]; g = pix_q[15:8]; bl = b;
							pix_n = '0; pph_n = 2'd0;
						end
					endcase
					left_n = left_q - W'(1);
					if (left_q == W'(1)) begin
						fin_n = 1'b1; phase_n = aicp_pkg::P_END;
					end
				end
				aicp_pkg::P_BID: begin
					cnt_n = cnt_q; field_n = field_q;
					if (b == aicp_pkg::ID_HEADER) phase_n = aicp_pkg::P_LHDR;
					else if (b == aicp_pkg::ID_CREDITS) phase_n = aicp_pkg::P_LCRED;
					else if (b == aicp_pkg::ID_ANIM) phase_n = aicp_pkg::P_LANIM;
					else err_n = aicp_pkg::ERR_BLOCK_ID;
				end
				aicp_pkg::P_CSKIP: begin
					cnt_n = cnt_q; field_n = field_q;
					left_n = left_q - W'(1);
					if (left_q == W'(1)) phase_n = aicp_pkg::P_BID;
				end
				default: begin
					cnt_n = cnt_q; field_n = field_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= aicp_pkg::P_MAGIC; cnt_q <= '0; field_q <= '0;
			blen_q <= '0; hrem_q <= '0; hshort_q <= 1'b0;
			content_q <= '0; w3_q <= '0; prod_q <= '0; cap_q <= '0; left_q <= '0;
			pix_q <= '0; pph_q <= '0; err_q <= '0; fin_q <= 1'b0; out_valid <= 1'b0;
		end else if (mode_we) begin
			// Restart from the reset state in the new mode.
			phase_q <= mode_wdata ? aicp_pkg::P_BID : aicp_pkg::P_MAGIC;
			cnt_q <= '0; field_q <= '0;
			blen_q <= '0; hrem_q <= '0; hshort_q <= 1'b0;
			content_q <= '0; w3_q <= '0; prod_q <= '0; cap_q <= '0; left_q <= '0;
			pix_q <= '0; pph_q <= '0; err_q <= '0; fin_q <= 1'b0;
		end else begin
			// Hold the result until taken; load a new one on every pop.
			out_valid <= pop || (out_valid && !out_ready);
			if (pop) begin
				phase_q <= phase_n; cnt_q <= cnt_n; field_q <= field_n;
				blen_q <= blen_n; hrem_q <= hrem_n;
				hshort_q <= hshort_n; content_q <= content_n; w3_q <= w3_n;
				prod_q <= prod_n; cap_q <= cap_n; left_q <= left_n;
				pix_q <= pix_n; pph_q <= pph_n; err_q <= err_n; fin_q <= fin_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			pixel_valid <= pv; red <= r; green <= g; blue <= bl;
			tag_end <= te; warning <= warn; error_code <= err_n; done_res <= fin_n;
		end
	end

endmodule

[rtl/core/animated_image_container_parser_unit.sv]
// Top level of the animated image container parser.
// Depends on aicp_pkg, aicp_queue and aicp_parser.

// Parses one byte per clock unless out_ready stalls it: every accepted
// data_byte yields exactly one result beat, in order. A two-entry byte queue
// decouples the input channel from the parse state machine, and the parser's
// result register decouples it from the output channel, so with out_ready
// held high the block sustains one beat per cycle. Each byte passes through
// the queue and its result beat is then loaded into the result register,
// where it is held until taken. While out_ready is low the queue fills and
// in_ready drops once it holds two bytes. The only multiply on the per-byte
// path is a SIZE_WIDTH by 8 multiply-accumulate used while the height field
// streams in, which keeps the width*height*3 check at one byte per cycle.
// Write mode only while the block is idle; a write restarts the parser in
// the new mode (0 bare image, 1 container).
module animated_image_container_parser_unit #(
	parameter int SIZE_WIDTH = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       mode_we,
	input  logic       mode_wdata,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       pixel_valid,
	output logic [7:0] red,
	output logic [7:0] green,
	output logic [7:0] blue,
	output logic       tag_end,
	output logic [1:0] warning,
	output logic [3:0] error_code,
	output logic       done_res
);

	aicp_pkg::q_head_t head;
	logic              pop;

	// Front: hold incoming beats.
	aicp_queue u_queue (
		.clk, .arst_n, .in_valid, .in_ready, .data_byte, .pop, .head
	);

	// Back: advance the parse one byte per pop.
	aicp_parser #(.SIZE_WIDTH(SIZE_WIDTH)) u_parser (
		.clk, .arst_n, .mode_we, .mode_wdata, .head, .pop,
		.out_valid, .out_ready, .pixel_valid, .red, .green, .blue,
		.tag_end, .warning, .error_code, .done_res
	);

endmodule

[rtl/core/aicp_checker.sv]
// Port-level checks for the parser top level, attached by bind.
// Depends only on the top level's ports.
module aicp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic       pixel_valid,
	input logic [7:0] red,
	input logic [7:0] green,
	input logic [7:0] blue,
	input logic       tag_end,
	input logic [1:0] warning,
	input logic [3:0] error_code
);

	a_color_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !pixel_valid |-> red == 8'd0 && green == 8'd0 && blue == 8'd0)
		else $error("color nonzero without pixel");

	a_err_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_code != 4'd0 |-> !pixel_valid && !tag_end)
		else $error("activity after error");

	a_warn_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> warning != 2'd3)
		else $error("bad warning code");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(error_code) && $stable(red))
		else $error("result changed while stalled");

endmodule

bind animated_image_container_parser_unit aicp_checker u_aicp_checker (.*);
